FILE: rtl/ddpc_pkg.sv
// ddpc_pkg: shared types, constants and helpers for the differential drive pid controller
// used by the controller, datapath and top level; depends on nothing else

package ddpc_pkg;

   // fixed block constants
   localparam int CONTROL_RATE_HZ = 1000;
   localparam int MAX_PWM         = 1024;
   localparam int BRAKE_TICKS     = 3000;

   // quotient bits: pwm magnitude before saturation is always below MAX_PWM
   localparam int QW  = $clog2(MAX_PWM);
   localparam int DCW = $clog2(QW);

   // number of gain products per tick (three loops, three gains each)
   localparam int MUL_TERMS = 9;

   // reciprocal of the tick rate, scaled by 2^32 and rounded up
   localparam logic [26:0] RATE_RECIP =
      27'(((64'd1 << 32) + 64'(CONTROL_RATE_HZ) - 64'd1) / 64'(CONTROL_RATE_HZ));

   localparam logic [16:0] PWM_LIMIT   = 17'(MAX_PWM);
   localparam logic [11:0] BRAKE_LOAD  = 12'(BRAKE_TICKS);

   // register indexes
   localparam logic [2:0] REG_ACCEL_HARD  = 3'd0;
   localparam logic [2:0] REG_ACCEL_SOFT  = 3'd1;
   localparam logic [2:0] REG_HARD_LIMIT  = 3'd2;
   localparam logic [2:0] REG_BRAKE_DECEL = 3'd3;
   localparam logic [2:0] REG_LINE_ON     = 3'd4;
   localparam logic [2:0] REG_LIN_GAINS   = 3'd5;
   localparam logic [2:0] REG_ANG_GAINS   = 3'd6;
   localparam logic [2:0] REG_LINE_GAINS  = 3'd7;

   // motor modes
   localparam logic [1:0] MODE_DISABLED = 2'd0;
   localparam logic [1:0] MODE_BRAKE    = 2'd1;
   localparam logic [1:0] MODE_DRIVE    = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_FRONT,
      ST_ERR,
      ST_MUL,
      ST_DRAIN,
      ST_MIX,
      ST_SCALE,
      ST_DIVINIT,
      ST_DIV,
      ST_STORE,
      ST_OUT
   } state_type;

   // controller to datapath commands
   typedef struct packed {
      logic       capture;
      logic       front;
      logic       errs;
      logic       mul_pid;
      logic [3:0] term;
      logic       mix;
      logic       scale;
      logic       side;
      logic       div_init;
      logic       div_step;
      logic       store;
      logic       out_load;
   } cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic run;
   } status_type;

   // signed 32-bit add with saturation
   function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [31:0] b);
      logic [32:0] s;
      begin
         s = {a[31], a} + {b[31], b};
         if (s[32] != s[31]) begin
            sat_add32 = s[32] ? 32'h8000_0000 : 32'h7fff_ffff;
         end else begin
            sat_add32 = s[31:0];
         end
      end
   endfunction

endpackage

FILE: rtl/ddpc_ctrl.sv
// ddpc_ctrl: sequencer for one control tick, drives the datapath by command struct
// depends on ddpc_pkg

module ddpc_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  ddpc_pkg::status_type status,
   output ddpc_pkg::cmd_type    cmd
);
   import ddpc_pkg::*;

   state_type        state_ff, state_in;
   logic [3:0]       term_ff, term_in;
   logic [DCW-1:0]   dcnt_ff, dcnt_in;
   logic             side_ff, side_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             can_load;

   assign can_load = !rsp_valid_ff || rsp_ready;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:    if (req_valid) state_in = ST_FRONT;
         ST_FRONT:   state_in = status.run ? ST_ERR : ST_OUT;
         ST_ERR:     state_in = ST_MUL;
         ST_MUL:     if (term_ff == 4'(MUL_TERMS - 1)) state_in = ST_DRAIN;
         ST_DRAIN:   state_in = ST_MIX;
         ST_MIX:     state_in = ST_SCALE;
         ST_SCALE:   state_in = ST_DIVINIT;
         ST_DIVINIT: state_in = ST_DIV;
         ST_DIV:     if (dcnt_ff == DCW'(QW - 1)) state_in = ST_STORE;
         ST_STORE:   state_in = side_ff ? ST_OUT : ST_SCALE;
         ST_OUT:     if (can_load) state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   // counters and result valid
   always_comb begin
      term_in      = term_ff;
      dcnt_in      = dcnt_ff;
      side_in      = side_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;
      case (state_ff)
         ST_ERR: begin
            term_in = 4'd0;
            side_in = 1'b0;
         end
         ST_MUL:     term_in = term_ff + 4'd1;
         ST_DIVINIT: dcnt_in = '0;
         ST_DIV:     dcnt_in = dcnt_ff + DCW'(1);
         ST_STORE:   side_in = 1'b1;
         ST_OUT:     if (can_load) rsp_valid_in = 1'b1;
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         term_ff      <= 4'd0;
         dcnt_ff      <= '0;
         side_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         term_ff      <= term_in;
         dcnt_ff      <= dcnt_in;
         side_ff      <= side_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // command decode
   always_comb begin
      cmd          = '0;
      cmd.term     = term_ff;
      cmd.side     = side_ff;
      cmd.capture  = (state_ff == ST_IDLE) && req_valid;
      cmd.front    = (state_ff == ST_FRONT);
      cmd.errs     = (state_ff == ST_ERR);
      cmd.mul_pid  = (state_ff == ST_MUL);
      cmd.mix      = (state_ff == ST_MIX);
      cmd.scale    = (state_ff == ST_SCALE);
      cmd.div_init = (state_ff == ST_DIVINIT);
      cmd.div_step = (state_ff == ST_DIV);
      cmd.store    = (state_ff == ST_STORE);
      cmd.out_load = (state_ff == ST_OUT) && can_load;
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

FILE: rtl/ddpc_datapath.sv
// ddpc_datapath: config registers, loop state, shared multiplier, pwm divider, result register
// depends on ddpc_pkg

module ddpc_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  ddpc_pkg::cmd_type    cmd,
   output ddpc_pkg::status_type status,
   input  logic                 csr_wr_en,
   input  logic [2:0]           csr_index,
   input  logic [47:0]          csr_wdata,
   input  logic                 req_run_active,
   input  logic signed [15:0]   req_target_speed,
   input  logic                 req_force_speed,
   input  logic signed [15:0]   req_angular_target,
   input  logic signed [15:0]   req_left_wheel_speed,
   input  logic signed [15:0]   req_right_wheel_speed,
   input  logic signed [15:0]   req_gyro_rate,
   input  logic signed [15:0]   req_line_position,
   input  logic [13:0]          req_battery_mv,
   output logic signed [11:0]   rsp_left_pwm,
   output logic signed [11:0]   rsp_right_pwm,
   output logic [1:0]           rsp_motor_mode,
   output logic signed [15:0]   rsp_ideal_speed_out
);
   import ddpc_pkg::*;

   // configuration registers
   logic [15:0] accel_hard_ff, accel_soft_ff, brake_decel_ff;
   logic [14:0] hard_limit_ff;
   logic        line_on_ff;
   logic [47:0] lin_gains_ff, ang_gains_ff, line_gains_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         accel_hard_ff  <= '0;
         accel_soft_ff  <= '0;
         hard_limit_ff  <= '0;
         brake_decel_ff <= '0;
         line_on_ff     <= 1'b0;
         lin_gains_ff   <= '0;
         ang_gains_ff   <= '0;
         line_gains_ff  <= '0;
      end else if (csr_wr_en) begin
         case (csr_index)
            REG_ACCEL_HARD:  accel_hard_ff  <= csr_wdata[15:0];
            REG_ACCEL_SOFT:  accel_soft_ff  <= csr_wdata[15:0];
            REG_HARD_LIMIT:  hard_limit_ff  <= csr_wdata[14:0];
            REG_BRAKE_DECEL: brake_decel_ff <= csr_wdata[15:0];
            REG_LINE_ON:     line_on_ff     <= csr_wdata[0];
            REG_LIN_GAINS:   lin_gains_ff   <= csr_wdata;
            REG_ANG_GAINS:   ang_gains_ff   <= csr_wdata;
            REG_LINE_GAINS:  line_gains_ff  <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // per-tick ramp steps: acceleration over tick rate by reciprocal multiply
   logic [42:0] hard_prod, soft_prod, brake_prod;
   logic [10:0] hard_step_ff, soft_step_ff, brake_step_ff;

   assign hard_prod  = 43'(accel_hard_ff)  * 43'(RATE_RECIP);
   assign soft_prod  = 43'(accel_soft_ff)  * 43'(RATE_RECIP);
   assign brake_prod = 43'(brake_decel_ff) * 43'(RATE_RECIP);

   always_ff @(posedge clock) begin
      hard_step_ff  <= hard_prod[42:32];
      soft_step_ff  <= soft_prod[42:32];
      brake_step_ff <= brake_prod[42:32];
   end

   // input beat capture
   logic               run_ff, force_ff;
   logic signed [15:0] target_ff, ang_t_ff, wl_ff, wr_ff, gyro_ff, linepos_ff;
   logic [31:0]        t_ff;
   logic [13:0]        bat_eff;

   assign bat_eff = (req_battery_mv == 14'd0) ? 14'd1 : req_battery_mv;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         run_ff     <= req_run_active;
         force_ff   <= req_force_speed;
         target_ff  <= req_target_speed;
         ang_t_ff   <= req_angular_target;
         wl_ff      <= req_left_wheel_speed;
         wr_ff      <= req_right_wheel_speed;
         gyro_ff    <= req_gyro_rate;
         linepos_ff <= req_line_position;
         t_ff       <= {bat_eff, 18'd0};
      end
   end

   assign status.run = run_ff;

   // loop state
   logic signed [15:0] ideal_ff;
   logic signed [16:0] lin_prev_ff, ang_prev_ff;
   logic signed [15:0] line_prev_ff;
   logic [31:0]        lin_sum_ff, ang_sum_ff, line_sum_ff;
   logic               was_running_ff;
   logic [11:0]        timer_ff;
   logic signed [16:0] le_ff, ae_ff;
   logic signed [15:0] se_ff;

   // run edges and brake timer
   logic        start_edge, stop_edge, any_edge;
   logic [11:0] timer_eff;

   assign start_edge = run_ff && !was_running_ff;
   assign stop_edge  = !run_ff && was_running_ff;
   assign any_edge   = start_edge || stop_edge;

   always_comb begin
      timer_eff = timer_ff;
      if (start_edge) timer_eff = 12'd0;
      else if (stop_edge) timer_eff = BRAKE_LOAD;
   end

   // ideal speed ramp
   logic signed [15:0] base, cur, ramp;
   logic signed [17:0] up, dn, tgt18;
   logic [10:0]        up_step;
   logic               use_hard;

   always_comb begin
      base     = any_edge ? 16'sd0 : ideal_ff;
      cur      = force_ff ? target_ff : base;
      use_hard = (hard_limit_ff == 15'd0) ||
                 ($signed({cur[15], cur}) < $signed({2'b00, hard_limit_ff}));
      up_step  = use_hard ? hard_step_ff : soft_step_ff;
      tgt18    = {{2{target_ff[15]}}, target_ff};
      up       = {{2{cur[15]}}, cur} + $signed({7'd0, up_step});
      dn       = {{2{cur[15]}}, cur} - $signed({7'd0, brake_step_ff});
      if (cur < target_ff) begin
         ramp = (up > tgt18) ? target_ff : up[15:0];
      end else if (cur > target_ff) begin
         ramp = (dn < tgt18) ? target_ff : dn[15:0];
      end else begin
         ramp = cur;
      end
   end

   // errors of this tick
   logic signed [16:0] wsum, wadj, half, le_in, ae_in;
   logic signed [15:0] se_in;

   always_comb begin
      wsum  = {wl_ff[15], wl_ff} + {wr_ff[15], wr_ff};
      wadj  = wsum + 17'(wsum[16]);
      half  = wadj >>> 1;
      le_in = {ideal_ff[15], ideal_ff} - half;
      ae_in = {ang_t_ff[15], ang_t_ff} + {gyro_ff[15], gyro_ff};
      se_in = line_on_ff ? linepos_ff : 16'sd0;
   end

   // mixed voltages and pwm staging
   logic signed [63:0] lin_acc_ff, ang_acc_ff, vl_ff, vr_ff;
   logic [1:0]         mode_ff;
   logic [11:0]        pwm_l_ff, pwm_r_ff;

   // shared multiplier
   logic signed [17:0] mul_a;
   logic signed [33:0] mul_b;
   logic signed [51:0] prod_ff;
   logic               acc_en_ff;
   logic [3:0]         tag_ff;
   logic signed [17:0] lin_d, ang_d;
   logic signed [16:0] line_d;
   logic signed [63:0] v_sel;
   logic [63:0]        mag;
   logic               neg_ff, sat_ff;

   assign lin_d  = {le_ff[16], le_ff} - {lin_prev_ff[16], lin_prev_ff};
   assign ang_d  = {ae_ff[16], ae_ff} - {ang_prev_ff[16], ang_prev_ff};
   assign line_d = {se_ff[15], se_ff} - {line_prev_ff[15], line_prev_ff};

   assign v_sel = cmd.side ? vr_ff : vl_ff;
   assign mag   = v_sel[63] ? 64'(-v_sel) : 64'(v_sel);

   // operand select: gain field by term, or pwm scale of the magnitude
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      if (cmd.scale) begin
         mul_a = $signed({1'b0, PWM_LIMIT});
         mul_b = $signed({2'b00, mag[31:0]});
      end else begin
         case (cmd.term)
            4'd0: begin
               mul_a = $signed({2'b00, lin_gains_ff[15:0]});
               mul_b = 34'(le_ff);
            end
            4'd1: begin
               mul_a = $signed({2'b00, lin_gains_ff[31:16]});
               mul_b = 34'($signed(lin_sum_ff));
            end
            4'd2: begin
               mul_a = $signed({2'b00, lin_gains_ff[47:32]});
               mul_b = 34'(lin_d);
            end
            4'd3: begin
               mul_a = $signed({2'b00, ang_gains_ff[15:0]});
               mul_b = 34'(ae_ff);
            end
            4'd4: begin
               mul_a = $signed({2'b00, ang_gains_ff[31:16]});
               mul_b = 34'($signed(ang_sum_ff));
            end
            4'd5: begin
               mul_a = $signed({2'b00, ang_gains_ff[47:32]});
               mul_b = 34'(ang_d);
            end
            4'd6: begin
               mul_a = $signed({2'b00, line_gains_ff[15:0]});
               mul_b = 34'(se_ff);
            end
            4'd7: begin
               mul_a = $signed({2'b00, line_gains_ff[31:16]});
               mul_b = 34'($signed(line_sum_ff));
            end
            4'd8: begin
               mul_a = $signed({2'b00, line_gains_ff[47:32]});
               mul_b = 34'(line_d);
            end
            default: begin
               mul_a = '0;
               mul_b = '0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
      tag_ff  <= cmd.term;
   end

   always_ff @(posedge clock) begin
      if (reset) acc_en_ff <= 1'b0;
      else acc_en_ff <= cmd.mul_pid;
   end

   // product accumulate: linear and line terms carry a factor of 1024
   logic signed [63:0] p64, p_sh;

   assign p64  = {{12{prod_ff[51]}}, prod_ff};
   assign p_sh = {p64[53:0], 10'd0};

   always_ff @(posedge clock) begin
      if (cmd.errs) begin
         lin_acc_ff <= '0;
         ang_acc_ff <= '0;
      end else if (acc_en_ff) begin
         if (tag_ff < 4'd3) lin_acc_ff <= lin_acc_ff + p_sh;
         else if (tag_ff < 4'd6) ang_acc_ff <= ang_acc_ff + p64;
         else ang_acc_ff <= ang_acc_ff + p_sh;
      end
      if (cmd.mix) begin
         vl_ff <= lin_acc_ff + ang_acc_ff;
         vr_ff <= lin_acc_ff - ang_acc_ff;
      end
   end

   // loop state update
   always_ff @(posedge clock) begin
      if (reset) begin
         ideal_ff       <= '0;
         lin_prev_ff    <= '0;
         ang_prev_ff    <= '0;
         line_prev_ff   <= '0;
         lin_sum_ff     <= '0;
         ang_sum_ff     <= '0;
         line_sum_ff    <= '0;
         was_running_ff <= 1'b0;
         timer_ff       <= '0;
      end else begin
         if (cmd.front) begin
            was_running_ff <= run_ff;
            if (any_edge) begin
               lin_prev_ff  <= '0;
               ang_prev_ff  <= '0;
               line_prev_ff <= '0;
               lin_sum_ff   <= '0;
               ang_sum_ff   <= '0;
               line_sum_ff  <= '0;
            end
            if (run_ff) begin
               ideal_ff <= ramp;
               timer_ff <= timer_eff;
            end else begin
               ideal_ff <= base;
               timer_ff <= (timer_eff != 12'd0) ? timer_eff - 12'd1 : 12'd0;
            end
         end
         if (cmd.errs) begin
            lin_sum_ff <= sat_add32(lin_sum_ff, 32'(le_in));
            ang_sum_ff <= sat_add32(ang_sum_ff, 32'(ae_in));
            if (line_on_ff) line_sum_ff <= sat_add32(line_sum_ff, 32'(se_in));
         end
         if (cmd.mix) begin
            lin_prev_ff  <= le_ff;
            ang_prev_ff  <= ae_ff;
            line_prev_ff <= se_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.errs) begin
         le_ff <= le_in;
         ae_ff <= ae_in;
         se_ff <= se_in;
      end
   end

   // pwm divider: restoring, one quotient bit a cycle
   logic [31:0]   rem_ff;
   logic [QW-1:0] qr_ff;
   logic [32:0]   trial, tdiff;
   logic          ge;
   logic [16:0]   pmag;
   logic [17:0]   psgn;

   assign trial = {rem_ff, qr_ff[QW-1]};
   assign tdiff = trial - {1'b0, t_ff};
   assign ge    = trial >= {1'b0, t_ff};
   assign pmag  = sat_ff ? PWM_LIMIT : 17'(qr_ff);
   assign psgn  = neg_ff ? 18'(-{1'b0, pmag}) : {1'b0, pmag};

   always_ff @(posedge clock) begin
      if (cmd.scale) begin
         neg_ff <= v_sel[63];
         sat_ff <= mag >= {32'd0, t_ff};
      end
      if (cmd.div_init) begin
         rem_ff <= prod_ff[QW+31:QW];
         qr_ff  <= prod_ff[QW-1:0];
      end else if (cmd.div_step) begin
         rem_ff <= ge ? tdiff[31:0] : trial[31:0];
         qr_ff  <= {qr_ff[QW-2:0], ge};
      end
   end

   // result staging and output register
   always_ff @(posedge clock) begin
      if (cmd.front) begin
         if (run_ff) begin
            mode_ff <= MODE_DRIVE;
         end else begin
            mode_ff  <= (timer_eff != 12'd0) ? MODE_BRAKE : MODE_DISABLED;
            pwm_l_ff <= '0;
            pwm_r_ff <= '0;
         end
      end
      if (cmd.store) begin
         if (cmd.side) pwm_r_ff <= psgn[11:0];
         else pwm_l_ff <= psgn[11:0];
      end
      if (cmd.out_load) begin
         rsp_left_pwm        <= $signed(pwm_l_ff);
         rsp_right_pwm       <= $signed(pwm_r_ff);
         rsp_motor_mode      <= mode_ff;
         rsp_ideal_speed_out <= ideal_ff;
      end
   end

endmodule

FILE: rtl/differential_drive_pid_controller_core.sv
// differential_drive_pid_controller_core: top level of the drive controller
// depends on ddpc_pkg, ddpc_ctrl and ddpc_datapath

// One request beat is one control tick; one response beat comes back per tick.
// In a running tick the nine gain products go one per cycle through a single
// shared multiplier, then each wheel's pwm is divided by the battery voltage
// in an iterative divider that makes one quotient bit a cycle. A stopped tick
// goes from the front step straight to the output step. A new tick is accepted
// only once the previous one has been handed to the response register, which
// can hold a finished beat while the next tick is already being computed.
// The user must write registers through the csr port only while no tick is
// in flight; the block itself does not enforce this.

module differential_drive_pid_controller_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_wr_en,
   input  logic [2:0]         csr_index,
   input  logic [47:0]        csr_wdata,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_run_active,
   input  logic signed [15:0] req_target_speed,
   input  logic               req_force_speed,
   input  logic signed [15:0] req_angular_target,
   input  logic signed [15:0] req_left_wheel_speed,
   input  logic signed [15:0] req_right_wheel_speed,
   input  logic signed [15:0] req_gyro_rate,
   input  logic signed [15:0] req_line_position,
   input  logic [13:0]        req_battery_mv,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [11:0] rsp_left_pwm,
   output logic signed [11:0] rsp_right_pwm,
   output logic [1:0]         rsp_motor_mode,
   output logic signed [15:0] rsp_ideal_speed_out
);
   import ddpc_pkg::*;

   cmd_type    cmd;
   status_type status;

   // tick sequencer
   ddpc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // arithmetic and state
   ddpc_datapath u_datapath (
      .clock                 (clock),
      .reset                 (reset),
      .cmd                   (cmd),
      .status                (status),
      .csr_wr_en             (csr_wr_en),
      .csr_index             (csr_index),
      .csr_wdata             (csr_wdata),
      .req_run_active        (req_run_active),
      .req_target_speed      (req_target_speed),
      .req_force_speed       (req_force_speed),
      .req_angular_target    (req_angular_target),
      .req_left_wheel_speed  (req_left_wheel_speed),
      .req_right_wheel_speed (req_right_wheel_speed),
      .req_gyro_rate         (req_gyro_rate),
      .req_line_position     (req_line_position),
      .req_battery_mv        (req_battery_mv),
      .rsp_left_pwm          (rsp_left_pwm),
      .rsp_right_pwm         (rsp_right_pwm),
      .rsp_motor_mode        (rsp_motor_mode),
      .rsp_ideal_speed_out   (rsp_ideal_speed_out)
   );

endmodule

FILE: tb/testbench.sv
// testbench: self-checking bench for differential_drive_pid_controller_core
// depends on ddpc_pkg and the core rtl; drives ticks, predicts pwm and mode, checks each beat

module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import ddpc_pkg::*;

   localparam int CYCLE_LIMIT = 2000000;

   typedef struct {
      logic        run;
      logic [15:0] target;
      logic        force_spd;
      logic [15:0] ang_t;
      logic [15:0] wl;
      logic [15:0] wr;
      logic [15:0] gyro;
      logic [15:0] linepos;
      logic [13:0] bat;
   } tick_t;

   typedef struct packed {
      logic [11:0] pwm_l;
      logic [11:0] pwm_r;
      logic [1:0]  mode;
      logic [15:0] ideal;
   } drive_t;

   // directed row: tick plus optional hand-typed expectation
   typedef struct {
      tick_t  tk;
      logic   typed;
      drive_t want;
   } row_t;

   logic        clock = 0;
   logic        reset = 1;
   logic        csr_wr_en = 0;
   logic [2:0]  csr_index = '0;
   logic [47:0] csr_wdata = '0;
   logic        req_valid = 0;
   logic        req_ready;
   logic        req_run_active = 0;
   logic signed [15:0] req_target_speed = '0;
   logic        req_force_speed = 0;
   logic signed [15:0] req_angular_target = '0;
   logic signed [15:0] req_left_wheel_speed = '0;
   logic signed [15:0] req_right_wheel_speed = '0;
   logic signed [15:0] req_gyro_rate = '0;
   logic signed [15:0] req_line_position = '0;
   logic [13:0] req_battery_mv = '0;
   logic        rsp_valid;
   logic        rsp_ready = 0;
   logic signed [11:0] rsp_left_pwm;
   logic signed [11:0] rsp_right_pwm;
   logic [1:0]  rsp_motor_mode;
   logic signed [15:0] rsp_ideal_speed_out;

   differential_drive_pid_controller_core dut (.*);

   always #1 clock = ~clock;

   // predictor copy of configuration and loop state
   longint unsigned m_accel_hard, m_accel_soft, m_hard_lim, m_brake;
   longint unsigned m_line_on, m_lin_g, m_ang_g, m_line_g;
   int m_ideal, m_lin_prev, m_ang_prev, m_line_prev, m_lin_sum, m_ang_sum, m_line_sum;
   bit m_was_run;
   int m_brake_cnt;

   drive_t pending_drive[$];
   logic   pending_typed[$];
   drive_t pending_typed_val[$];
   int     fail_count = 0;
   int     cycle_count = 0;

   function automatic int sat32(longint v);
      if (v > 64'sd2147483647) return 32'sh7fffffff;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return int'(v);
   endfunction

   function automatic longint pid_sum(longint unsigned g, int e, int s, int p);
      longint kp, ki, kd;
      kp = longint'(g[15:0]);
      ki = longint'(g[31:16]);
      kd = longint'(g[47:32]);
      return kp * e + ki * s + kd * (longint'(e) - p);
   endfunction

   function automatic logic [11:0] volt_to_pwm(longint v, longint unsigned b);
      longint unsigned mag, lim, p;
      longint s;
      mag = v < 0 ? longint'(-v) : longint'(v);
      lim = b << 18;
      p = (mag >= lim) ? 64'(MAX_PWM) : mag * 64'(MAX_PWM) / lim;
      s = v < 0 ? -longint'(p) : longint'(p);
      return s[11:0];
   endfunction

   function automatic void predictor_clear();
      m_ideal = 0; m_lin_prev = 0; m_ang_prev = 0; m_line_prev = 0;
      m_lin_sum = 0; m_ang_sum = 0; m_line_sum = 0;
   endfunction

   function automatic void model_csr(logic [2:0] idx, logic [47:0] d);
      case (idx)
         REG_ACCEL_HARD:  m_accel_hard = d[15:0];
         REG_ACCEL_SOFT:  m_accel_soft = d[15:0];
         REG_HARD_LIMIT:  m_hard_lim = d[14:0];
         REG_BRAKE_DECEL: m_brake = d[15:0];
         REG_LINE_ON:     m_line_on = d[0];
         REG_LIN_GAINS:   m_lin_g = d;
         REG_ANG_GAINS:   m_ang_g = d;
         REG_LINE_GAINS:  m_line_g = d;
         default: ;
      endcase
   endfunction

   // one control tick of the predictor
   function automatic drive_t predict_drive(tick_t t);
      drive_t r;
      int tgt, le, ae, se;
      longint unsigned b, a;
      longint vlin, vang;
      b = t.bat == 0 ? 1 : t.bat;
      tgt = int'($signed(t.target));
      if (t.run && !m_was_run) begin
         predictor_clear();
         m_brake_cnt = 0;
      end else if (!t.run && m_was_run) begin
         predictor_clear();
         m_brake_cnt = int'(BRAKE_LOAD);
      end
      m_was_run = t.run;
      if (!t.run) begin
         r.pwm_l = '0;
         r.pwm_r = '0;
         if (m_brake_cnt > 0) begin
            r.mode = MODE_BRAKE;
            m_brake_cnt--;
         end else begin
            r.mode = MODE_DISABLED;
         end
         r.ideal = m_ideal[15:0];
         return r;
      end
      if (t.force_spd) m_ideal = tgt;
      if (m_ideal < tgt) begin
         a = m_accel_soft;
         if (m_hard_lim == 0 || m_ideal < int'(m_hard_lim)) a = m_accel_hard;
         m_ideal += int'(a / CONTROL_RATE_HZ);
         if (m_ideal > tgt) m_ideal = tgt;
      end else if (m_ideal > tgt) begin
         m_ideal -= int'(m_brake / CONTROL_RATE_HZ);
         if (m_ideal < tgt) m_ideal = tgt;
      end
      le = m_ideal - (int'($signed(t.wl)) + int'($signed(t.wr))) / 2;
      m_lin_sum = sat32(longint'(m_lin_sum) + le);
      ae = int'($signed(t.ang_t)) + int'($signed(t.gyro));
      m_ang_sum = sat32(longint'(m_ang_sum) + ae);
      se = 0;
      if (m_line_on != 0) begin
         se = int'($signed(t.linepos));
         m_line_sum = sat32(longint'(m_line_sum) + se);
      end
      vlin = pid_sum(m_lin_g, le, m_lin_sum, m_lin_prev) * 1024;
      vang = pid_sum(m_ang_g, ae, m_ang_sum, m_ang_prev)
           + pid_sum(m_line_g, se, m_line_sum, m_line_prev) * 1024;
      m_lin_prev = le;
      m_ang_prev = ae;
      m_line_prev = se;
      r.pwm_l = volt_to_pwm(vlin + vang, b);
      r.pwm_r = volt_to_pwm(vlin - vang, b);
      r.mode = MODE_DRIVE;
      r.ideal = m_ideal[15:0];
      return r;
   endfunction

   // response side: random stall pattern, compare each beat
   int stall_mode = 0;
   always @(negedge clock) begin
      if (!reset) begin
         case (stall_mode)
            0: rsp_ready <= 1'b1;
            1: rsp_ready <= ($urandom_range(0, 3) != 0);
            2: rsp_ready <= ($urandom_range(0, 3) == 0);
            default: rsp_ready <= ~rsp_ready;
         endcase
         if ($urandom_range(0, 99) == 0) stall_mode = $urandom_range(0, 3);
      end
   end

   always @(posedge clock) begin
      drive_t w;
      logic   ty;
      drive_t tv;
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_drive.size() == 0) begin
            $display("%0t: response beat with nothing expected", $realtime);
            fail_count++;
         end else begin
            w = pending_drive.pop_front();
            ty = pending_typed.pop_front();
            tv = pending_typed_val.pop_front();
            if (ty && tv != w) begin
               $display("%0t: typed row disagrees exp %p act %p", $realtime, tv, w);
               fail_count++;
            end
            if (rsp_left_pwm !== w.pwm_l) begin
               $display("%0t: left pwm exp %0d act %0d", $realtime,
                        $signed(w.pwm_l), rsp_left_pwm);
               fail_count++;
            end
            if (rsp_right_pwm !== w.pwm_r) begin
               $display("%0t: right pwm exp %0d act %0d", $realtime,
                        $signed(w.pwm_r), rsp_right_pwm);
               fail_count++;
            end
            if (rsp_motor_mode !== w.mode) begin
               $display("%0t: motor_mode exp %0d act %0d", $realtime, w.mode,
                        rsp_motor_mode);
               fail_count++;
            end
            if (rsp_ideal_speed_out !== w.ideal) begin
               $display("%0t: ideal_speed exp %0d act %0d", $realtime,
                        $signed(w.ideal), rsp_ideal_speed_out);
               fail_count++;
            end
         end
      end
   end

   // drive one tick beat; hold until accepted, then predict
   task automatic send_tick(tick_t t, logic typed, drive_t want);
      req_valid <= 1'b1;
      req_run_active <= t.run;
      req_target_speed <= t.target;
      req_force_speed <= t.force_spd;
      req_angular_target <= t.ang_t;
      req_left_wheel_speed <= t.wl;
      req_right_wheel_speed <= t.wr;
      req_gyro_rate <= t.gyro;
      req_line_position <= t.linepos;
      req_battery_mv <= t.bat;
      do @(posedge clock); while (!req_ready);
      pending_drive.push_back(predict_drive(t));
      pending_typed.push_back(typed);
      pending_typed_val.push_back(want);
      @(negedge clock);
   endtask

   // sender bursts: random gap, possibly none, before each burst
   int burst_left = 0;
   task automatic send_paced(tick_t t);
      drive_t nz;
      int     gap;
      nz = '{default: '0};
      if (burst_left == 0) begin
         gap = $urandom_range(0, 1) ? int'($urandom_range(1, 80)) : 0;
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 20);
      end
      burst_left--;
      send_tick(t, 1'b0, nz);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_drive.size() != 0) @(negedge clock);
      repeat (60) @(negedge clock);
   endtask

   // one write beat, then the csr port is left idle before returning
   task automatic write_csr(logic [2:0] idx, logic [47:0] d);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= d;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      model_csr(idx, d);
      @(negedge clock);
   endtask

   function automatic logic [15:0] rnd16();
      case ($urandom_range(0, 5))
         0: return 16'h8000;
         1: return 16'h7fff;
         2: return 16'(int'($urandom_range(0, 400)) - 200);
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [47:0] rnd_gains();
      logic [47:0] g;
      g = {16'($urandom), 16'($urandom), 16'($urandom)};
      case ($urandom_range(0, 3))
         0: g = g & 48'h00ff_00ff_00ff;
         1: g = g & 48'h0fff_000f_ffff;
         2: g = '0;
         default: ;
      endcase
      return g;
   endfunction

   function automatic tick_t rnd_tick(logic run);
      tick_t t;
      t.run = run;
      t.target = ($urandom_range(0, 3) == 0) ? rnd16() : 16'($urandom_range(0, 3000));
      t.force_spd = ($urandom_range(0, 7) == 0);
      t.ang_t = rnd16();
      t.wl = rnd16();
      t.wr = rnd16();
      t.gyro = rnd16();
      t.linepos = rnd16();
      case ($urandom_range(0, 7))
         0: t.bat = 14'd0;
         1: t.bat = 14'h3fff;
         2: t.bat = 14'($urandom_range(1, 20));
         default: t.bat = 14'($urandom);
      endcase
      return t;
   endfunction

   function automatic row_t mk_row(logic run, int tgt, logic f, int wl, int wr,
                                   int ang, int gy, int lp, int bat, logic typed,
                                   logic [1:0] mode, int pl, int pr, int ideal);
      row_t r;
      r.tk = '{run, 16'(tgt), f, 16'(ang), 16'(wl), 16'(wr), 16'(gy), 16'(lp), 14'(bat)};
      r.typed = typed;
      r.want = '{12'(pl), 12'(pr), mode, 16'(ideal)};
      return r;
   endfunction

   row_t directed[$];
   int   n_run;

   initial begin
      m_accel_hard = 0; m_accel_soft = 0; m_hard_lim = 0; m_brake = 0;
      m_line_on = 0; m_lin_g = 0; m_ang_g = 0; m_line_g = 0;
      predictor_clear();
      m_was_run = 0;
      m_brake_cnt = 0;
      repeat (4) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // after reset: stopped, no gains -> disabled, zero pwm
      directed.push_back(mk_row(0, 100, 0, 0, 0, 0, 0, 0, 5000, 1, MODE_DISABLED, 0, 0, 0));
      // zero gains: running gives zero pwm, force sets speed directly
      directed.push_back(mk_row(1, 32767, 1, 0, 0, 0, 0, 0, 0, 1, MODE_DRIVE, 0, 0, 32767));
      directed.push_back(mk_row(1, -32768, 1, 0, 0, 0, 0, 0, 16383, 1, MODE_DRIVE, 0, 0,
                                -32768));
      // stop: brake window begins
      directed.push_back(mk_row(0, 0, 0, 0, 0, 0, 0, 0, 1, 1, MODE_BRAKE, 0, 0, 0));
      directed.push_back(mk_row(0, 0, 0, 0, 0, 0, 0, 0, 1, 1, MODE_BRAKE, 0, 0, 0));
      foreach (directed[i]) send_tick(directed[i].tk, directed[i].typed, directed[i].want);
      wait_drained();
      directed.delete();

      // large gains, extremes of every field, line on, hard/soft ramp
      write_csr(REG_ACCEL_HARD, 48'd65535);
      write_csr(REG_ACCEL_SOFT, 48'd2500);
      write_csr(REG_HARD_LIMIT, 48'd300);
      write_csr(REG_BRAKE_DECEL, 48'd65535);
      write_csr(REG_LINE_ON, 48'd1);
      write_csr(REG_LIN_GAINS, 48'hffff_ffff_ffff);
      write_csr(REG_ANG_GAINS, 48'h0100_0010_0200);
      write_csr(REG_LINE_GAINS, 48'h0001_0001_0001);
      directed.push_back(mk_row(1, 1000, 0, 0, 0, 0, 0, 0, 5000, 0, 0, 0, 0, 0));
      directed.push_back(mk_row(1, 1000, 0, 0, 0, 0, 0, 0, 5000, 0, 0, 0, 0, 0));
      directed.push_back(mk_row(1, 1000, 0, 0, 0, 0, 0, 0, 5000, 0, 0, 0, 0, 0));
      directed.push_back(mk_row(1, -32768, 0, 32767, 32767, 32767, 32767, 32767, 0,
                                0, 0, 0, 0, 0));
      directed.push_back(mk_row(1, 5, 1, -32768, -32768, -32768, -32768, -32768, 16383,
                                0, 0, 0, 0, 0));
      directed.push_back(mk_row(1, 5, 0, -1, 0, 3, -3, 100, 1, 0, 0, 0, 0, 0));
      directed.push_back(mk_row(1, 5, 0, 1, 0, 0, 0, 0, 16383, 0, 0, 0, 0, 0));
      directed.push_back(mk_row(0, 5, 0, 0, 0, 0, 0, 0, 100, 1, MODE_BRAKE, 0, 0, 0));
      foreach (directed[i]) send_tick(directed[i].tk, directed[i].typed, directed[i].want);
      wait_drained();

      // random phases, each with its own register setting
      for (int ph = 0; ph < 8; ph++) begin
         write_csr(REG_ACCEL_HARD, (ph == 1) ? 48'd0 : 48'($urandom_range(0, 65535)));
         write_csr(REG_ACCEL_SOFT, 48'($urandom_range(0, 65535)));
         write_csr(REG_HARD_LIMIT, (ph == 2) ? 48'd32767 :
                                   (ph == 3) ? 48'd0 : 48'($urandom_range(0, 2000)));
         write_csr(REG_BRAKE_DECEL, (ph == 1) ? 48'd0 : 48'($urandom_range(0, 65535)));
         write_csr(REG_LINE_ON, 48'(ph % 2));
         write_csr(REG_LIN_GAINS, rnd_gains());
         write_csr(REG_ANG_GAINS, rnd_gains());
         write_csr(REG_LINE_GAINS, rnd_gains());
         for (int i = 0; i < 117; i++) begin
            // mostly long runs, occasional stop ticks
            n_run = ($urandom_range(0, 9) == 0) ? 0 : 1;
            send_paced(rnd_tick(n_run[0]));
         end
         wait_drained();
      end

      if (fail_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

FILE: filelist.f
rtl/ddpc_pkg.sv
rtl/ddpc_ctrl.sv
rtl/ddpc_datapath.sv
rtl/differential_drive_pid_controller_core.sv
tb/testbench.sv
